// ===== hdl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMPL(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

// ===== hdl/ffa_pkg.sv =====
`default_nettype none
package ffa_pkg;

  localparam int NUM_HOLES  = 64;
  localparam int NUM_BLOCKS = 256;
  localparam int ADDR_W     = 64;
  localparam int SIZE_W     = 34;
  localparam int CNT_W      = $clog2((NUM_BLOCKS > NUM_HOLES) ? NUM_BLOCKS : NUM_HOLES);
  localparam logic [11:0]       PAGE_MASK = 12'hfff;
  localparam logic [SIZE_W:0]   MAX_REQ   = 35'd8589934592;

  typedef enum logic [1:0] {OP_ALLOC, OP_FREE, OP_QUERY, OP_NONE} op_e;
  typedef enum logic [1:0] {ST_OK, ST_ZERO, ST_NOSPACE, ST_UNKNOWN} status_e;

  typedef enum logic [3:0] {
    S_IDLE, S_HFIND, S_APICK, S_ACHK, S_LFIND, S_LDEC, S_KFIND,
    S_PFIND, S_PDEC, S_HUPD, S_TAIL, S_LUPD, S_DONE
  } state_e;

  typedef struct packed {
    logic              vld;
    logic [ADDR_W-1:0] start;
    logic [ADDR_W-1:0] len;
  } hole_t;

  typedef struct packed {
    logic              vld;
    logic [ADDR_W-1:0] start;
    logic [SIZE_W-1:0] len;
  } live_t;

endpackage
`default_nettype wire

// ===== hdl/ffa_hole_ring.sv =====
`default_nettype none
module ffa_hole_ring import ffa_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  shift_i,
  input  hole_t tail_i,
  output hole_t head_o
);

  logic [NUM_HOLES-1:0] vld_q;
  logic [ADDR_W-1:0]    start_q [NUM_HOLES];
  logic [ADDR_W-1:0]    len_q   [NUM_HOLES];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (shift_i) begin
      vld_q <= {tail_i.vld, vld_q[NUM_HOLES-1:1]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      for (int i = 0; i < NUM_HOLES - 1; i++) begin
        start_q[i] <= start_q[i+1];
        len_q[i]   <= len_q[i+1];
      end
      start_q[NUM_HOLES-1] <= tail_i.start;
      len_q[NUM_HOLES-1]   <= tail_i.len;
    end
  end

  assign head_o = '{vld: vld_q[0], start: start_q[0], len: len_q[0]};

endmodule
`default_nettype wire

// ===== hdl/ffa_live_ring.sv =====
`default_nettype none
module ffa_live_ring import ffa_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  shift_i,
  input  live_t tail_i,
  output live_t head_o
);

  logic [NUM_BLOCKS-1:0] vld_q;
  logic [ADDR_W-1:0]     start_q [NUM_BLOCKS];
  logic [SIZE_W-1:0]     len_q   [NUM_BLOCKS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (shift_i) begin
      vld_q <= {tail_i.vld, vld_q[NUM_BLOCKS-1:1]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      for (int i = 0; i < NUM_BLOCKS - 1; i++) begin
        start_q[i] <= start_q[i+1];
        len_q[i]   <= len_q[i+1];
      end
      start_q[NUM_BLOCKS-1] <= tail_i.start;
      len_q[NUM_BLOCKS-1]   <= tail_i.len;
    end
  end

  assign head_o = '{vld: vld_q[0], start: start_q[0], len: len_q[0]};

endmodule
`default_nettype wire

// ===== hdl/ffa_ctrl.sv =====
`default_nettype none
module ffa_ctrl import ffa_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  op_e               in_op_i,
  input  logic [SIZE_W-1:0] in_req_i,
  input  logic [ADDR_W-1:0] in_addr_i,
  input  logic              cfg_valid_i,
  input  logic [ADDR_W-1:0] cfg_data_i,
  output logic              hole_shift_o,
  output hole_t             hole_tail_o,
  input  hole_t             hole_head_i,
  output logic              live_shift_o,
  output live_t             live_tail_o,
  input  live_t             live_head_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [ADDR_W-1:0] out_addr_o,
  output logic [SIZE_W-1:0] out_size_o,
  output status_e           out_status_o
);

  state_e            state_q, state_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  op_e               op_q, op_d;
  logic [SIZE_W-1:0] want_q, want_d;
  logic [ADDR_W-1:0] key_q, key_d;
  logic [ADDR_W-1:0] base_q, base_d;
  logic [ADDR_W-1:0] comm_q, comm_d;
  logic [ADDR_W-1:0] edge_q, edge_d;
  logic              bf_q, bf_d;
  logic [ADDR_W-1:0] bstart_q, bstart_d;
  logic [ADDR_W-1:0] blen_q, blen_d;
  logic              kfound_q, kfound_d;
  logic              match_q, match_d;
  logic [SIZE_W-1:0] mlen_q, mlen_d;
  logic              lfree_q, lfree_d;
  logic              hfree_q, hfree_d;
  logic              pf_q, pf_d;
  logic [ADDR_W-1:0] pstart_q, pstart_d;
  logic [ADDR_W-1:0] plen_q, plen_d;
  logic              merge_q, merge_d;
  logic              changed_q, changed_d;
  logic              written_q, written_d;
  logic [ADDR_W-1:0] k_q, k_d;
  logic [ADDR_W-1:0] rem_q, rem_d;
  status_e           st_q, st_d;
  logic [SIZE_W-1:0] fs_q, fs_d;
  logic              ov_q, ov_d;
  logic [ADDR_W-1:0] oaddr_q, oaddr_d;
  logic [SIZE_W-1:0] osize_q, osize_d;
  status_e           ost_q, ost_d;

  logic              hole_pass, live_pass, pass_end, accept;
  logic              hole_slot_wr, live_slot_wr;
  logic              tail_hit;
  logic [SIZE_W:0]   want_full;
  logic [ADDR_W:0]   end_full;

  assign hole_pass = (state_q == S_HFIND) || (state_q == S_KFIND) || (state_q == S_PFIND) ||
                     (state_q == S_HUPD) || (state_q == S_TAIL);
  assign live_pass = (state_q == S_LFIND) || (state_q == S_LUPD);
  assign pass_end  = (hole_pass && cnt_q == CNT_W'(NUM_HOLES - 1)) ||
                     (live_pass && cnt_q == CNT_W'(NUM_BLOCKS - 1));
  assign accept    = in_valid_i && in_ready_o;
  assign want_full = ({1'b0, in_req_i} + {{(SIZE_W - 11){1'b0}}, PAGE_MASK}) &
                     ~{{(SIZE_W - 11){1'b0}}, PAGE_MASK};
  assign end_full  = {1'b0, key_q} + {{(ADDR_W - SIZE_W + 1){1'b0}}, want_q};
  assign tail_hit  = hole_head_i.vld && hole_head_i.start < edge_q &&
                     hole_head_i.start + hole_head_i.len == edge_q;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          unique case (in_op_i)
            OP_ALLOC: begin
              if (in_req_i == '0 || want_full > MAX_REQ) state_d = S_DONE;
              else state_d = S_HFIND;
            end
            OP_FREE, OP_QUERY: state_d = S_LFIND;
            OP_NONE:           state_d = S_DONE;
          endcase
        end
      end
      S_HFIND: if (pass_end) state_d = S_APICK;
      S_APICK: state_d = S_ACHK;
      S_ACHK: begin
        if (!bf_q && (key_q < base_q || end_full[ADDR_W])) state_d = S_DONE;
        else state_d = S_LFIND;
      end
      S_LFIND: if (pass_end) state_d = S_LDEC;
      S_LDEC: begin
        unique case (op_q)
          OP_ALLOC: begin
            if (!match_q && !lfree_q) state_d = S_DONE;
            else if (bf_q) state_d = (rem_q != '0) ? S_KFIND : S_HUPD;
            else state_d = S_LUPD;
          end
          OP_FREE: begin
            if (!match_q) state_d = S_DONE;
            else if (key_q + ADDR_W'(mlen_q) == base_q + comm_q) state_d = S_TAIL;
            else state_d = S_PFIND;
          end
          OP_QUERY, OP_NONE: state_d = S_DONE;
        endcase
      end
      S_KFIND: if (pass_end) state_d = S_HUPD;
      S_PFIND: if (pass_end) state_d = S_PDEC;
      S_PDEC: begin
        if (!(pf_q && pstart_q + plen_q == key_q) && !kfound_q && !hfree_q) state_d = S_DONE;
        else state_d = S_HUPD;
      end
      S_HUPD: if (pass_end) state_d = S_LUPD;
      S_TAIL: if (pass_end && !changed_q && !tail_hit) state_d = S_LUPD;
      S_LUPD: if (pass_end) state_d = S_DONE;
      S_DONE: if (!ov_q || out_ready_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // ring controls
  always_comb begin
    hole_shift_o = hole_pass;
    live_shift_o = live_pass;
    hole_tail_o  = hole_head_i;
    live_tail_o  = live_head_i;
    hole_slot_wr = 1'b0;
    live_slot_wr = 1'b0;
    in_ready_o   = (state_q == S_IDLE);
    priority case (state_q)
      S_HUPD: begin
        if (op_q == OP_ALLOC) begin
          if (hole_head_i.vld && hole_head_i.start == bstart_q) begin
            if (rem_q == '0 || kfound_q) begin
              hole_tail_o.vld = 1'b0;
            end else begin
              hole_tail_o.start = k_q;
              hole_tail_o.len   = rem_q;
            end
          end else if (hole_head_i.vld && kfound_q && hole_head_i.start == k_q) begin
            hole_tail_o.len = rem_q;
          end
        end else if (merge_q) begin
          if (hole_head_i.vld && hole_head_i.start == pstart_q) begin
            hole_tail_o.len = hole_head_i.len + ADDR_W'(mlen_q);
          end else if (hole_head_i.vld && hole_head_i.start == key_q) begin
            hole_tail_o.vld = 1'b0;
          end
        end else if (kfound_q) begin
          if (hole_head_i.vld && hole_head_i.start == key_q) begin
            hole_tail_o.len = ADDR_W'(mlen_q);
          end
        end else if (!hole_head_i.vld && !written_q) begin
          hole_slot_wr = 1'b1;
          hole_tail_o  = '{vld: 1'b1, start: key_q, len: ADDR_W'(mlen_q)};
        end
      end
      S_TAIL: begin
        if (hole_head_i.vld && (hole_head_i.start >= edge_q ||
                                hole_head_i.start + hole_head_i.len == edge_q)) begin
          hole_tail_o.vld = 1'b0;
        end
      end
      S_LUPD: begin
        if (op_q == OP_ALLOC) begin
          if (match_q) begin
            if (live_head_i.vld && live_head_i.start == key_q) live_tail_o.len = want_q;
          end else if (!live_head_i.vld && !written_q) begin
            live_slot_wr = 1'b1;
            live_tail_o  = '{vld: 1'b1, start: key_q, len: want_q};
          end
        end else if (live_head_i.vld && live_head_i.start == key_q) begin
          live_tail_o.vld = 1'b0;
        end
      end
      default: ;
    endcase
  end

  // datapath
  always_comb begin
    cnt_d     = (hole_pass || live_pass) ? (pass_end ? '0 : cnt_q + 1'b1) : '0;
    op_d      = op_q;
    want_d    = want_q;
    key_d     = key_q;
    base_d    = cfg_valid_i ? cfg_data_i : base_q;
    comm_d    = comm_q;
    edge_d    = edge_q;
    bf_d      = bf_q;
    bstart_d  = bstart_q;
    blen_d    = blen_q;
    kfound_d  = kfound_q;
    match_d   = match_q;
    mlen_d    = mlen_q;
    lfree_d   = lfree_q;
    hfree_d   = hfree_q;
    pf_d      = pf_q;
    pstart_d  = pstart_q;
    plen_d    = plen_q;
    merge_d   = merge_q;
    changed_d = changed_q;
    written_d = written_q || hole_slot_wr || live_slot_wr;
    k_d       = k_q;
    rem_d     = rem_q;
    st_d      = st_q;
    fs_d      = fs_q;
    ov_d      = ov_q && !out_ready_i;
    oaddr_d   = oaddr_q;
    osize_d   = osize_q;
    ost_d     = ost_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          op_d      = in_op_i;
          key_d     = in_addr_i;
          want_d    = want_full[SIZE_W-1:0];
          bf_d      = 1'b0;
          kfound_d  = 1'b0;
          match_d   = 1'b0;
          lfree_d   = 1'b0;
          hfree_d   = 1'b0;
          pf_d      = 1'b0;
          merge_d   = 1'b0;
          changed_d = 1'b0;
          written_d = 1'b0;
          fs_d      = '0;
          st_d      = ST_OK;
          if (in_op_i == OP_ALLOC) begin
            if (in_req_i == '0) st_d = ST_ZERO;
            else if (want_full > MAX_REQ) st_d = ST_NOSPACE;
          end
        end
      end
      S_HFIND: begin
        if (hole_head_i.vld && hole_head_i.len >= ADDR_W'(want_q) &&
            (!bf_q || hole_head_i.start < bstart_q)) begin
          bf_d     = 1'b1;
          bstart_d = hole_head_i.start;
          blen_d   = hole_head_i.len;
        end
      end
      S_APICK: key_d = bf_q ? bstart_q : base_q + comm_q;
      S_ACHK: begin
        k_d   = end_full[ADDR_W-1:0];
        rem_d = blen_q - ADDR_W'(want_q);
        if (!bf_q && (key_q < base_q || end_full[ADDR_W])) st_d = ST_NOSPACE;
      end
      S_LFIND: begin
        if (live_head_i.vld && live_head_i.start == key_q) begin
          match_d = 1'b1;
          mlen_d  = live_head_i.len;
        end
        if (!live_head_i.vld) lfree_d = 1'b1;
      end
      S_LDEC: begin
        unique case (op_q)
          OP_ALLOC: begin
            if (!match_q && !lfree_q) st_d = ST_NOSPACE;
            else if (!bf_q) comm_d = comm_q + ADDR_W'(want_q);
          end
          OP_FREE: begin
            if (!match_q) st_d = ST_UNKNOWN;
            edge_d = key_q;
          end
          OP_QUERY: begin
            if (match_q) fs_d = mlen_q;
            else st_d = ST_UNKNOWN;
          end
          OP_NONE: ;
        endcase
      end
      S_KFIND: if (hole_head_i.vld && hole_head_i.start == k_q) kfound_d = 1'b1;
      S_PFIND: begin
        if (hole_head_i.vld && hole_head_i.start < key_q &&
            (!pf_q || hole_head_i.start > pstart_q)) begin
          pf_d     = 1'b1;
          pstart_d = hole_head_i.start;
          plen_d   = hole_head_i.len;
        end
        if (hole_head_i.vld && hole_head_i.start == key_q) kfound_d = 1'b1;
        if (!hole_head_i.vld) hfree_d = 1'b1;
      end
      S_PDEC: begin
        merge_d = pf_q && (pstart_q + plen_q == key_q);
        if (!merge_d && !kfound_q && !hfree_q) st_d = ST_NOSPACE;
      end
      S_TAIL: begin
        if (tail_hit) begin
          edge_d    = hole_head_i.start;
          changed_d = 1'b1;
        end
        if (pass_end) begin
          changed_d = 1'b0;
          if (!changed_q && !tail_hit) comm_d = edge_q - base_q;
        end
      end
      S_DONE: begin
        if (!ov_q || out_ready_i) begin
          ov_d    = 1'b1;
          oaddr_d = (op_q == OP_ALLOC && st_q == ST_OK) ? key_q : '0;
          osize_d = fs_q;
          ost_d   = st_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      cnt_q     <= '0;
      base_q    <= '0;
      comm_q    <= '0;
      ov_q      <= 1'b0;
      written_q <= 1'b0;
      changed_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      base_q    <= base_d;
      comm_q    <= comm_d;
      ov_q      <= ov_d;
      written_q <= written_d;
      changed_q <= changed_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    want_q   <= want_d;
    key_q    <= key_d;
    edge_q   <= edge_d;
    bf_q     <= bf_d;
    bstart_q <= bstart_d;
    blen_q   <= blen_d;
    kfound_q <= kfound_d;
    match_q  <= match_d;
    mlen_q   <= mlen_d;
    lfree_q  <= lfree_d;
    hfree_q  <= hfree_d;
    pf_q     <= pf_d;
    pstart_q <= pstart_d;
    plen_q   <= plen_d;
    merge_q  <= merge_d;
    k_q      <= k_d;
    rem_q    <= rem_d;
    st_q     <= st_d;
    fs_q     <= fs_d;
    oaddr_q  <= oaddr_d;
    osize_q  <= osize_d;
    ost_q    <= ost_d;
  end

  assign out_valid_o  = ov_q;
  assign out_addr_o   = oaddr_q;
  assign out_size_o   = osize_q;
  assign out_status_o = ost_q;

endmodule
`default_nettype wire

// ===== hdl/first_fit_heap_allocator_top.sv =====
// Page-granular first-fit heap allocator.
// Input stream (s_axis): tuser = op (0 alloc, 1 free, 2 query), tdata = request_size
// and block_addr. One item is taken at a time; tready is high only while idle.
// Output stream (m_axis): one result item per input item, held in an output register,
// so the next input item is taken while a result still waits for m_axis_tready.
// Configuration channel: cfg_valid_i/cfg_data_i write arena_base, always ready.
// State sits in two rings of cells (64 hole entries, 256 block entries) that rotate one
// entry per cycle during a scan, past a single compare point; every scan is one full
// rotation. Query: a block scan. Allocate: a hole scan, a block scan, up to two hole
// passes (none from the committed edge) and a block write pass. Free: a block scan,
// then a hole scan and hole and block write passes, or, when the block ends at the
// committed edge, hole passes while that edge shrinks, then a block write pass. Invalid
// ops answer without a scan. A result that waits for m_axis_tready holds the next item
// in its last cycle. Reset clears all entry valid bits, the committed size and
// arena_base at once; the block is ready as soon as reset is released.
`default_nettype none
`include "assert_macros.svh"
module first_fit_heap_allocator_top import ffa_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [103:0] s_axis_tdata,  // request_size[33:0], block_addr[97:34], zero pad
  input  logic [1:0]   s_axis_tuser,  // op[1:0]
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [103:0] m_axis_tdata,  // result_addr[63:0], found_size[97:64], zero pad
  output logic [1:0]   m_axis_tuser,  // status[1:0]
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [63:0]  cfg_data_i
);

  hole_t             hole_tail, hole_head;
  live_t             live_tail, live_head;
  logic              hole_shift, live_shift;
  logic [ADDR_W-1:0] out_addr;
  logic [SIZE_W-1:0] out_size;
  status_e           out_status;

  assign cfg_ready_o = 1'b1;

  ffa_hole_ring u_holes (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .shift_i (hole_shift),
    .tail_i  (hole_tail),
    .head_o  (hole_head)
  );

  ffa_live_ring u_blocks (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .shift_i (live_shift),
    .tail_i  (live_tail),
    .head_o  (live_head)
  );

  ffa_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_op_i      (op_e'(s_axis_tuser)),
    .in_req_i     (s_axis_tdata[33:0]),
    .in_addr_i    (s_axis_tdata[97:34]),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_data_i   (cfg_data_i),
    .hole_shift_o (hole_shift),
    .hole_tail_o  (hole_tail),
    .hole_head_i  (hole_head),
    .live_shift_o (live_shift),
    .live_tail_o  (live_tail),
    .live_head_i  (live_head),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_addr_o   (out_addr),
    .out_size_o   (out_size),
    .out_status_o (out_status)
  );

  assign m_axis_tdata = {6'b0, out_size, out_addr};
  assign m_axis_tuser = out_status;

  `ASSERT_NEXT(a_one_item, s_axis_tvalid && s_axis_tready, !s_axis_tready, "second item taken while busy")
  `ASSERT_IMPL(a_addr_ok, m_axis_tvalid && m_axis_tuser != ST_OK, m_axis_tdata[63:0] == '0, "address on failed result")
  `ASSERT_IMPL(a_size_ok, m_axis_tvalid && m_axis_tdata[97:64] != '0, m_axis_tuser == ST_OK, "size on failed result")
  `ASSERT_IMPL(a_size_page, m_axis_tvalid, m_axis_tdata[75:64] == '0, "size not page aligned")

endmodule
`default_nettype wire
